// File: src/c3rc_pkg.sv
// Shared types and constants of the 3x3 replicate-clamp convolution core.
package c3rc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int WIDTH_REG_W = 11;
   localparam int COEFF_W     = 48;
   localparam int WEIGHT_W    = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_TOP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_MIDDLE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEFF_BOTTOM  = 2'd3;

   localparam int PROD_W    = 25;
   localparam int SUM_W     = 27;
   localparam int ACC_W     = 29;
   localparam int FRAC_BITS = 12;

   localparam logic [ACC_W-1:0]   ROUND_BIAS = 29'd2048;
   localparam logic [PIXEL_W-1:0] PIXEL_MAX  = 8'd255;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [8:0][PIXEL_W-1:0] window_type;
   typedef logic [2:0][COEFF_W-1:0] coeff_type;

   typedef struct packed {
      logic last_in_run;
      logic end_of_row;
      logic end_of_frame;
   } rsp_flags_type;

   typedef struct packed {
      rsp_flags_type flags;
      pixel_type     out_pixel;
   } result_type;

endpackage

// File: src/conv3x3_replicate_clamp_core.sv
// Streaming 3x3 convolution with edge replication, line buffers and result queue.
//
// Pixels arrive in raster order on the req_ channel, one beat per pixel; req_tuser
// marks a drain beat. After the last image row a row of drain beats flushes the
// final output row. Results leave on the rsp_ channel: rsp_tdata is the filtered
// pixel, rsp_tlast closes the results of one input beat, rsp_tuser flags end of
// row and end of frame. Weights and image width are written on the csr_ channel;
// the user must do so only while the core is idle, the core does not enforce it.
// Throughput: one input beat per cycle while the result queue has space; the
// beat at the last column of each row after the first produces two results and
// holds the input while the second is sent, as the multiply-accumulate pipeline
// takes one window per cycle. On its way to rsp_ a result passes the line buffer
// read, the window update, four filter stages and the result queue.
// Each output lags the input stream by one row and one pixel.
// Reset clears the window, the row position and the queue; line buffers are not
// cleared and are filled by the first row of each frame.
// When rsp_tready is low, up to eight results queue up; then the window stage
// holds and req_tready drops until space returns.
module conv3x3_replicate_clamp_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] pixel
   input  logic                                req_tuser,   // [0] drain
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_pixel
   output logic                                rsp_tlast,
   output logic [1:0]                          rsp_tuser,   // [0] end_of_row, [1] end_of_frame
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [c3rc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [c3rc_pkg::COEFF_W-1:0]        csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W > c3rc_pkg::WIDTH_REG_W) ? COL_W : c3rc_pkg::WIDTH_REG_W;
   localparam logic [CMP_W:0] MAX_W_V = (CMP_W+1)'(MAX_WIDTH);

   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_BODY  = 2'd1;
   localparam logic [1:0] PHASE_DRAIN = 2'd2;

   // configuration
   logic [c3rc_pkg::WIDTH_REG_W-1:0] width_ff;
   c3rc_pkg::coeff_type              coeff_ff;

   // row position
   logic [COL_W-1:0] column_ff, column_in;
   logic [1:0]       row_phase_ff, row_phase_in;

   // line buffers
   c3rc_pkg::pixel_type line_above_mem  [MAX_WIDTH];
   c3rc_pkg::pixel_type line_center_mem [MAX_WIDTH];
   c3rc_pkg::pixel_type rd_above_ff, rd_center_ff;
   logic                fwd_ff, fwd_in;
   c3rc_pkg::pixel_type fwd_above_ff, fwd_center_ff;

   // window stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_step_ff, s1_step_in;
   logic                s1_first_ff, s1_repl_ff, s1_zero_ff, s1_last_ff, s1_drow_ff;
   c3rc_pkg::pixel_type s1_pix_ff;
   logic [COL_W-1:0]    s1_addr_ff;
   c3rc_pkg::window_type win_ff, win_in;

   // result queue
   c3rc_pkg::result_type             fifo_mem [c3rc_pkg::FIFO_DEPTH];
   logic [c3rc_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [c3rc_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [c3rc_pkg::FIFO_CNT_W-1:0]  credit_ff, credit_in;

   // front-end decode
   logic [CMP_W:0]   w_ext, w_eff, last_col, c_ext, c_sel;
   logic [COL_W-1:0] c_new;
   logic             is_last, ignore, accept, load;
   logic [1:0]       ph_cur, ph_eff;

   // window stage control
   c3rc_pkg::pixel_type     top, mid, bot, wr_above, wr_center;
   logic                    need2, emit, can_emit, step_go, s1_done, emit_fire, win_upd;
   c3rc_pkg::rsp_flags_type flags;

   logic                    f_valid;
   c3rc_pkg::result_type    f_result;
   c3rc_pkg::result_type    head;
   logic                    pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= c3rc_pkg::WIDTH_RESET;
         coeff_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            c3rc_pkg::REG_IMAGE_WIDTH:  width_ff    <= csr_data[c3rc_pkg::WIDTH_REG_W-1:0];
            c3rc_pkg::REG_COEFF_TOP:    coeff_ff[0] <= csr_data;
            c3rc_pkg::REG_COEFF_MIDDLE: coeff_ff[1] <= csr_data;
            c3rc_pkg::REG_COEFF_BOTTOM: coeff_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_ext = (CMP_W+1)'(width_ff);
      if (width_ff == '0) begin
         w_eff = (CMP_W+1)'(1);
      end else if (w_ext > MAX_W_V) begin
         w_eff = MAX_W_V;
      end else begin
         w_eff = w_ext;
      end
      last_col = w_eff - (CMP_W+1)'(1);
      c_ext    = (CMP_W+1)'(column_ff);
      c_sel    = (c_ext >= last_col) ? last_col : c_ext;
      c_new    = c_sel[COL_W-1:0];
      is_last  = (c_sel == last_col);

      ph_cur = (row_phase_ff > PHASE_DRAIN) ? PHASE_FIRST : row_phase_ff;
      ignore = (ph_cur == PHASE_FIRST) && req_tuser;
      ph_eff = (ph_cur == PHASE_BODY && req_tuser && column_ff == '0) ? PHASE_DRAIN : ph_cur;

      accept = req_tvalid && req_tready;
      load   = accept && !ignore;

      column_in    = column_ff;
      row_phase_in = row_phase_ff;
      if (load) begin
         if (is_last) begin
            column_in    = '0;
            row_phase_in = (ph_eff == PHASE_DRAIN) ? PHASE_FIRST : PHASE_BODY;
         end else begin
            column_in    = c_new + COL_W'(1);
            row_phase_in = ph_eff;
         end
      end
   end

   always_comb begin
      top       = fwd_ff ? fwd_above_ff : rd_above_ff;
      mid       = fwd_ff ? fwd_center_ff : rd_center_ff;
      bot       = s1_repl_ff ? mid : s1_pix_ff;
      wr_above  = s1_first_ff ? s1_pix_ff : mid;
      wr_center = s1_first_ff ? s1_pix_ff : bot;

      need2     = !s1_first_ff && !s1_zero_ff && s1_last_ff;
      emit      = s1_valid_ff && !s1_first_ff && (s1_step_ff || !s1_zero_ff || s1_last_ff);
      can_emit  = credit_ff < c3rc_pkg::FIFO_CNT_W'(c3rc_pkg::FIFO_DEPTH);
      step_go   = s1_valid_ff && (!emit || can_emit);
      s1_done   = step_go && !(!s1_step_ff && need2);
      emit_fire = emit && can_emit;
      win_upd   = step_go && !s1_first_ff;

      win_in = win_ff;
      if (!s1_step_ff && s1_zero_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k]   = top;
            win_in[3+k] = mid;
            win_in[6+k] = bot;
         end
      end else begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = top;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = bot;
      end

      if (s1_step_ff || (s1_zero_ff && s1_last_ff)) begin
         flags.last_in_run  = 1'b1;
         flags.end_of_row   = 1'b1;
         flags.end_of_frame = s1_drow_ff;
      end else begin
         flags.last_in_run  = !s1_last_ff;
         flags.end_of_row   = 1'b0;
         flags.end_of_frame = 1'b0;
      end

      req_tready = !s1_valid_ff || s1_done;

      if (load) begin
         s1_valid_in = 1'b1;
         s1_step_in  = 1'b0;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_step_in  = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
         s1_step_in  = s1_step_ff || (step_go && need2);
      end

      fwd_in = load && s1_valid_ff && !s1_step_ff && (s1_addr_ff == c_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_phase_ff <= PHASE_FIRST;
         s1_valid_ff  <= 1'b0;
         s1_step_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         win_ff       <= '0;
      end else begin
         column_ff    <= column_in;
         row_phase_ff <= row_phase_in;
         s1_valid_ff  <= s1_valid_in;
         s1_step_ff   <= s1_step_in;
         if (load) begin
            fwd_ff <= fwd_in;
         end
         if (win_upd) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_first_ff   <= (ph_eff == PHASE_FIRST);
         s1_repl_ff    <= (ph_eff == PHASE_DRAIN) || req_tuser;
         s1_zero_ff    <= (c_new == '0);
         s1_last_ff    <= is_last;
         s1_drow_ff    <= (ph_eff == PHASE_DRAIN);
         s1_pix_ff     <= req_tdata;
         s1_addr_ff    <= c_new;
         fwd_above_ff  <= wr_above;
         fwd_center_ff <= wr_center;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && !s1_step_ff) begin
         line_above_mem[s1_addr_ff]  <= wr_above;
         line_center_mem[s1_addr_ff] <= wr_center;
      end
      if (load) begin
         rd_above_ff  <= line_above_mem[c_new];
         rd_center_ff <= line_center_mem[c_new];
      end
   end

   c3rc_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (emit_fire),
      .in_window  (win_in),
      .in_flags   (flags),
      .coeff      (coeff_ff),
      .out_valid  (f_valid),
      .out_result (f_result)
   );

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tdata  = head.out_pixel;
   assign rsp_tlast  = head.flags.last_in_run;
   assign rsp_tuser  = {head.flags.end_of_frame, head.flags.end_of_row};

   always_comb begin
      count_in  = count_ff + c3rc_pkg::FIFO_CNT_W'(f_valid) - c3rc_pkg::FIFO_CNT_W'(pop);
      credit_in = credit_ff + c3rc_pkg::FIFO_CNT_W'(emit_fire) - c3rc_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         count_ff  <= count_in;
         credit_ff <= credit_in;
         if (f_valid) begin
            wr_ptr_ff <= wr_ptr_ff + c3rc_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + c3rc_pkg::FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_valid) begin
         fifo_mem[wr_ptr_ff] <= f_result;
      end
   end

endmodule

// File: src/c3rc_filter.sv
// Pipelined 3x3 multiply-accumulate with rounding and clamping to 0..255.
module c3rc_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  c3rc_pkg::window_type   in_window,
   input  c3rc_pkg::rsp_flags_type in_flags,
   input  c3rc_pkg::coeff_type    coeff,
   output logic                   out_valid,
   output c3rc_pkg::result_type   out_result
);

   logic                                  a_valid_ff;
   c3rc_pkg::window_type                  a_win_ff;
   c3rc_pkg::rsp_flags_type               a_flags_ff;

   logic                                  b_valid_ff;
   logic signed [c3rc_pkg::PROD_W-1:0]    prod_ff [9];
   c3rc_pkg::rsp_flags_type               b_flags_ff;

   logic                                  c_valid_ff;
   logic signed [c3rc_pkg::SUM_W-1:0]     row_ff [3];
   c3rc_pkg::rsp_flags_type               c_flags_ff;

   logic                                  d_valid_ff;
   c3rc_pkg::result_type                  d_result_ff;

   logic signed [c3rc_pkg::ACC_W-1:0]     acc;
   logic        [c3rc_pkg::ACC_W-1:0]     rnd;
   logic        [c3rc_pkg::ACC_W-c3rc_pkg::FRAC_BITS-1:0] rnd_int;
   c3rc_pkg::pixel_type                   clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_win_ff   <= in_window;
      a_flags_ff <= in_flags;
      b_flags_ff <= a_flags_ff;
      c_flags_ff <= b_flags_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r*3+c] <=
               c3rc_pkg::PROD_W'($signed(coeff[r][c3rc_pkg::WEIGHT_W*c +: c3rc_pkg::WEIGHT_W]))
               * c3rc_pkg::PROD_W'($signed({1'b0, a_win_ff[(2-r)*3+(2-c)]}));
         end
      end
      for (int r = 0; r < 3; r++) begin
         row_ff[r] <= c3rc_pkg::SUM_W'(prod_ff[r*3])
                    + c3rc_pkg::SUM_W'(prod_ff[r*3+1])
                    + c3rc_pkg::SUM_W'(prod_ff[r*3+2]);
      end
      d_result_ff.flags     <= c_flags_ff;
      d_result_ff.out_pixel <= clamped;
   end

   always_comb begin
      acc     = c3rc_pkg::ACC_W'(row_ff[0]) + c3rc_pkg::ACC_W'(row_ff[1])
              + c3rc_pkg::ACC_W'(row_ff[2]);
      rnd     = acc + c3rc_pkg::ROUND_BIAS;
      rnd_int = rnd[c3rc_pkg::ACC_W-1:c3rc_pkg::FRAC_BITS];
      if (acc[c3rc_pkg::ACC_W-1]) begin
         clamped = '0;
      end else if (rnd_int > (c3rc_pkg::ACC_W-c3rc_pkg::FRAC_BITS)'(c3rc_pkg::PIXEL_MAX)) begin
         clamped = c3rc_pkg::PIXEL_MAX;
      end else begin
         clamped = rnd_int[c3rc_pkg::PIXEL_W-1:0];
      end
   end

   assign out_valid  = d_valid_ff;
   assign out_result = d_result_ff;

endmodule
